FILE: src/hcbp_pkg.sv
// ----------------------------------------------------------------------------
// hcbp_pkg
// Shared widths, limits, action codes and the lookup struct for the code bit
// packer.
// ----------------------------------------------------------------------------
package hcbp_pkg;

  // field widths
  localparam int SYMBOL_W = 7;
  localparam int CODE_W   = 10;
  localparam int LEN_W    = 4;
  localparam int BYTE_W   = 8;
  localparam int USED_W   = 4;

  // longest stored code, longer lengths are clamped to it
  localparam int MAX_CODE_BITS = 10;

  // default table depth
  localparam int SYMBOL_COUNT_DEF = 128;

  // pending buffer: up to seven bits left over between words
  localparam int PEND_W  = 7;
  localparam int PCNT_W  = 3;
  // pending bits plus one code
  localparam int ACC_W   = PEND_W + MAX_CODE_BITS;
  // total bit count, up to seven plus the longest code
  localparam int NBITS_W = 5;

  // one table entry: code bits and length
  localparam int ENTRY_W = CODE_W + LEN_W;

  // action codes
  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_ENCODE = 1'b1;

  // table lookup handed to the pack stage
  typedef struct packed {
    logic              hit;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
  } lookup_t;

  // control of the word held in the pack stage
  typedef struct packed {
    logic enc;
    logic fin;
  } item_t;

endpackage

FILE: src/hcbp_if.sv
// ----------------------------------------------------------------------------
// hcbp_if
// Valid/ready stream interfaces: symbol words in, packed byte words out.
// ----------------------------------------------------------------------------
interface hcbp_sym_if;
  logic                          valid;
  logic                          ready;
  logic                          action;
  logic [hcbp_pkg::SYMBOL_W-1:0] symbol;
  logic [hcbp_pkg::CODE_W-1:0]   code_word;
  logic [hcbp_pkg::LEN_W-1:0]    code_length;
  logic                          final_symbol;

  modport source (
    output valid, action, symbol, code_word, code_length, final_symbol,
    input  ready
  );
  modport sink (
    input  valid, action, symbol, code_word, code_length, final_symbol,
    output ready
  );
endinterface

interface hcbp_byte_if;
  logic                        valid;
  logic                        ready;
  logic [hcbp_pkg::BYTE_W-1:0] out_byte;
  logic [hcbp_pkg::USED_W-1:0] used_bits;
  logic                        chunk_end;
  logic                        last;

  modport source (
    output valid, out_byte, used_bits, chunk_end, last,
    input  ready
  );
  modport sink (
    input  valid, out_byte, used_bits, chunk_end, last,
    output ready
  );
endinterface

FILE: src/hcbp_ram.sv
// ----------------------------------------------------------------------------
// hcbp_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module hcbp_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/hcbp_code_table.sv
// ----------------------------------------------------------------------------
// hcbp_code_table
// Code table: RAM of code/length entries plus a valid bit per entry, so an
// entry never loaded reads as zero length. Lookup data is registered when the
// word is accepted and is ready in the next cycle.
// ----------------------------------------------------------------------------
module hcbp_code_table #(
  parameter int SymbolCount = hcbp_pkg::SYMBOL_COUNT_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          acc_i,
  input  logic                          action_i,
  input  logic [hcbp_pkg::SYMBOL_W-1:0] symbol_i,
  input  logic [hcbp_pkg::CODE_W-1:0]   code_word_i,
  input  logic [hcbp_pkg::LEN_W-1:0]    code_length_i,
  output hcbp_pkg::lookup_t             lookup_o
);

  import hcbp_pkg::*;

  localparam int AddrW = $clog2(SymbolCount);

  logic                   in_range;
  logic [AddrW-1:0]       addr;
  logic                   wr_en;
  logic                   rd_en;
  logic [LEN_W-1:0]       len_c;
  logic [CODE_W:0]        mask_w;
  logic [CODE_W-1:0]      code_c;
  logic [ENTRY_W-1:0]     wdata;
  logic [ENTRY_W-1:0]     rdata;
  logic [SymbolCount-1:0] vld_q;
  logic                   hit_q;

  // address decode; symbols past the table are ignored
  assign in_range = 32'(symbol_i) < 32'(SymbolCount);
  assign addr     = AddrW'(symbol_i);
  assign wr_en    = acc_i && (action_i == ACT_LOAD) && in_range;
  assign rd_en    = acc_i && (action_i == ACT_ENCODE);

  // clamp the length and drop code bits above it
  always_comb begin
    if (code_length_i > LEN_W'(MAX_CODE_BITS)) begin
      len_c = LEN_W'(MAX_CODE_BITS);
    end else begin
      len_c = code_length_i;
    end
    mask_w = ((CODE_W + 1)'(1) << len_c) - (CODE_W + 1)'(1);
    code_c = code_word_i & mask_w[CODE_W-1:0];
  end

  assign wdata = {code_c, len_c};

  hcbp_ram #(
    .Width (ENTRY_W),
    .Depth (SymbolCount)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (addr),
    .wdata_i (wdata),
    .re_i    (rd_en),
    .raddr_i (addr),
    .rdata_o (rdata)
  );

  // per-entry valid bits, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_en) begin
      vld_q[addr] <= 1'b1;
    end
  end

  // hit flag sampled alongside the RAM read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else if (rd_en) begin
      hit_q <= in_range && vld_q[addr];
    end
  end

  assign lookup_o.hit  = hit_q;
  assign lookup_o.code = rdata[ENTRY_W-1:LEN_W];
  assign lookup_o.len  = rdata[LEN_W-1:0];

endmodule

FILE: src/hcbp_packer.sv
// ----------------------------------------------------------------------------
// hcbp_packer
// Pack stage: appends the looked-up code to the pending bits, splits off full
// bytes and the flush byte into a three-entry result buffer, and drains that
// buffer one word a cycle while the output is ready.
// ----------------------------------------------------------------------------
module hcbp_packer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        acc_i,
  input  hcbp_pkg::item_t             item_i,
  input  hcbp_pkg::lookup_t           lookup_i,
  output logic                        in_ready_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [hcbp_pkg::BYTE_W-1:0] out_byte_o,
  output logic [hcbp_pkg::USED_W-1:0] used_bits_o,
  output logic                        chunk_end_o,
  output logic                        last_o
);

  import hcbp_pkg::*;

  localparam int BufDepth = 3;

  // pack stage holding register
  logic              s1_vld_q;
  item_t             s1_q;

  // pending bit buffer
  logic [PEND_W-1:0] pend_q;
  logic [PCNT_W-1:0] pcnt_q;

  // result buffer
  logic [BYTE_W-1:0] byte_q [BufDepth];
  logic [USED_W-1:0] used_q [BufDepth];
  logic [1:0]        cnt_q;
  logic              fin_q;

  logic [LEN_W-1:0]   len_e;
  logic [CODE_W-1:0]  code_e;
  logic [ACC_W-1:0]   acc;
  logic [NBITS_W-1:0] nbits;
  logic [1:0]         nfull;
  logic [PCNT_W-1:0]  rem;
  logic [PEND_W:0]    rem_mask;
  logic [PEND_W-1:0]  rem_bits;
  logic [BYTE_W-1:0]  byte0;
  logic [BYTE_W-1:0]  byte1;
  logic [BYTE_W+PEND_W-1:0] flush_w;
  logic [BYTE_W-1:0]  flush_byte;
  logic               do_flush;
  logic [1:0]         res_cnt;
  logic               buf_free;
  logic               s1_adv;
  logic               buf_load;
  logic               pop;

  // code of this word; a miss or a load contributes nothing
  assign len_e  = (s1_q.enc && lookup_i.hit) ? lookup_i.len  : '0;
  assign code_e = (s1_q.enc && lookup_i.hit) ? lookup_i.code : '0;

  // append code to pending bits
  assign acc   = (ACC_W'(pend_q) << len_e) | ACC_W'(code_e);
  assign nbits = NBITS_W'(pcnt_q) + NBITS_W'(len_e);
  assign nfull = nbits[4:3];
  assign rem   = nbits[2:0];

  // full bytes, oldest bits first
  assign byte0 = BYTE_W'(acc >> (nbits - NBITS_W'(8)));
  assign byte1 = BYTE_W'(acc >> (nbits - NBITS_W'(16)));

  // leftover bits and their left-aligned flush byte
  assign rem_mask   = ((PEND_W + 1)'(1) << rem) - (PEND_W + 1)'(1);
  assign rem_bits   = acc[PEND_W-1:0] & rem_mask[PEND_W-1:0];
  assign flush_w    = {{BYTE_W{1'b0}}, rem_bits} << (4'd8 - {1'b0, rem});
  assign flush_byte = flush_w[BYTE_W-1:0];
  assign do_flush   = s1_q.enc && s1_q.fin && (rem != '0);
  assign res_cnt    = nfull + {1'b0, do_flush};

  // stage handshake
  assign pop        = (cnt_q != '0) && out_ready_i;
  assign buf_free   = (cnt_q == '0) || ((cnt_q == 2'd1) && out_ready_i);
  assign s1_adv     = s1_vld_q && ((res_cnt == '0) || buf_free);
  assign buf_load   = s1_adv && (res_cnt != '0);
  assign in_ready_o = !s1_vld_q || s1_adv;

  // pack stage occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (acc_i) begin
      s1_vld_q <= 1'b1;
    end else if (s1_adv) begin
      s1_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      s1_q <= item_i;
    end
  end

  // pending bits: kept remainder, cleared at the end of a chunk
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      pcnt_q <= '0;
    end else if (s1_adv && s1_q.enc) begin
      if (s1_q.fin) begin
        pend_q <= '0;
        pcnt_q <= '0;
      end else begin
        pend_q <= rem_bits;
        pcnt_q <= rem;
      end
    end
  end

  // result count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (buf_load) begin
      cnt_q <= res_cnt;
    end else if (pop) begin
      cnt_q <= cnt_q - 2'd1;
    end
  end

  // result payload: fill on load, shift towards the head on pop
  always_ff @(posedge clk_i) begin
    if (buf_load) begin
      byte_q[0] <= (nfull != '0)   ? byte0 : flush_byte;
      used_q[0] <= (nfull != '0)   ? USED_W'(8) : USED_W'(rem);
      byte_q[1] <= (nfull == 2'd2) ? byte1 : flush_byte;
      used_q[1] <= (nfull == 2'd2) ? USED_W'(8) : USED_W'(rem);
      byte_q[2] <= flush_byte;
      used_q[2] <= USED_W'(rem);
      fin_q     <= s1_q.fin;
    end else if (pop) begin
      byte_q[0] <= byte_q[1];
      used_q[0] <= used_q[1];
      byte_q[1] <= byte_q[2];
      used_q[1] <= used_q[2];
    end
  end

  // head of the buffer drives the output
  assign out_valid_o = (cnt_q != '0);
  assign out_byte_o  = byte_q[0];
  assign used_bits_o = used_q[0];
  assign last_o      = (cnt_q == 2'd1);
  assign chunk_end_o = (cnt_q == 2'd1) && fin_q;

endmodule

FILE: src/huffman_code_bit_packer_top.sv
// ----------------------------------------------------------------------------
// huffman_code_bit_packer_top
// Code table lookup and MSB-first bit packer producing bytes per chunk.
// ----------------------------------------------------------------------------
//   port    dir   word carried
//   sym_i   in    action, symbol, code_word, code_length, final_symbol
//   byte_o  out   out_byte, used_bits, chunk_end, last
//
// Table read and control are registered at the accepting edge; the word then
// passes the pack stage into the result buffer, whose head offers the first
// byte. A word gives up to three bytes, which leave one by one; one giving
// none leaves the pack stage without waiting on the buffer. Reset clears the
// per-entry valid bits at once, so no clearing pass runs. A stalled output
// holds the result buffer, which holds the pack stage and so stalls the input.
// ----------------------------------------------------------------------------
module huffman_code_bit_packer_top #(
  parameter int SymbolCount = hcbp_pkg::SYMBOL_COUNT_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  hcbp_sym_if.sink     sym_i,
  hcbp_byte_if.source  byte_o
);

  import hcbp_pkg::*;

  logic    in_acc;
  logic    in_ready;
  item_t   item;
  lookup_t lookup;

  assign in_acc      = sym_i.valid && in_ready;
  assign sym_i.ready = in_ready;

  assign item.enc = (sym_i.action == ACT_ENCODE);
  assign item.fin = sym_i.final_symbol;

  // table lookup / load
  hcbp_code_table #(
    .SymbolCount (SymbolCount)
  ) u_table (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .acc_i         (in_acc),
    .action_i      (sym_i.action),
    .symbol_i      (sym_i.symbol),
    .code_word_i   (sym_i.code_word),
    .code_length_i (sym_i.code_length),
    .lookup_o      (lookup)
  );

  // bit packing and output buffer
  hcbp_packer u_packer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (in_acc),
    .item_i      (item),
    .lookup_i    (lookup),
    .in_ready_o  (in_ready),
    .out_valid_o (byte_o.valid),
    .out_ready_i (byte_o.ready),
    .out_byte_o  (byte_o.out_byte),
    .used_bits_o (byte_o.used_bits),
    .chunk_end_o (byte_o.chunk_end),
    .last_o      (byte_o.last)
  );

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives symbol words into the code bit packer and checks every packed byte
// word against typed results or an in-bench model. A short table of directed
// words comes first, then table loads and chunks of encoded symbols with
// random content. Both sides idle at random. The receiver holds off once for
// a long stretch, and the sender twice pauses until the output has drained.
// ----------------------------------------------------------------------------
module testbench;
  import hcbp_pkg::*;

  localparam int HALF_PERIOD   = 5;
  localparam int RESET_CYCLES  = 8;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_WORDS  = 380;
  localparam int PRELOAD_WORDS = 40;
  localparam int HOLD_CYCLES   = 250;
  localparam int DRAIN_CYCLES  = 20;
  localparam int TYPED_NONE    = -1;

  // one symbol word as driven
  typedef struct packed {
    logic                action;
    logic [SYMBOL_W-1:0] symbol;
    logic [CODE_W-1:0]   code_word;
    logic [LEN_W-1:0]    code_length;
    logic                final_symbol;
  } sym_word_t;

  // one packed byte word as received
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic [USED_W-1:0] used;
    logic              chunk_end;
    logic              last;
  } packed_byte_t;

  // directed row: word plus hand-typed results where they are obvious
  typedef struct {
    sym_word_t    w;
    int           n_typed;
    packed_byte_t t0;
    packed_byte_t t1;
  } dir_row_t;

  localparam packed_byte_t NO_BYTE = '0;

  logic clk_i;
  logic rst_ni;

  hcbp_sym_if  sym_bus ();
  hcbp_byte_if byte_bus ();

  huffman_code_bit_packer_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sym_i  (sym_bus.sink),
    .byte_o (byte_bus.source)
  );

  // model state: code table and pending bit buffer
  logic [CODE_W-1:0] code_tbl [SYMBOL_COUNT_DEF];
  logic [LEN_W-1:0]  len_tbl  [SYMBOL_COUNT_DEF];
  logic [PEND_W-1:0] pend_bits;
  logic [PCNT_W-1:0] pend_cnt;

  packed_byte_t expected_bytes [$];
  dir_row_t     dir_rows [$];

  int errors      = 0;
  int cycle_cnt   = 0;
  int n_words     = 0;
  int n_results   = 0;
  int n_chunks    = 0;
  bit steady      = 1'b0;
  bit hold_req    = 1'b0;

  // clock and cycle count
  initial clk_i = 1'b0;
  always #HALF_PERIOD clk_i = ~clk_i;
  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  // watchdog
  initial begin : watchdog
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("%0t: timeout after %0d cycles, %0d bytes still awaited", $time,
             cycle_cnt, expected_bytes.size());
    $display("CHECKS FAILED");
    $finish;
  end

  // packer model: updates table and buffer, returns the bytes one word gives
  function automatic void pack_symbol(input sym_word_t w, output packed_byte_t res [3],
                                      output int cnt);
    logic [ACC_W-1:0]  acc;
    logic [LEN_W-1:0]  len;
    logic [CODE_W-1:0] code;
    int                n;
    cnt = 0;
    for (int i = 0; i < 3; i++) res[i] = NO_BYTE;
    if (w.action == ACT_LOAD) begin
      len = (w.code_length > MAX_CODE_BITS) ? LEN_W'(MAX_CODE_BITS) : w.code_length;
      code_tbl[w.symbol] = w.code_word & CODE_W'((1 << len) - 1);
      len_tbl[w.symbol]  = len;
      return;
    end
    len  = len_tbl[w.symbol];
    code = code_tbl[w.symbol];
    acc  = (ACC_W'(pend_bits) << len) | ACC_W'(code);
    n    = int'(pend_cnt) + int'(len);
    // full bytes, oldest bits first
    while (n >= 8) begin
      res[cnt] = {BYTE_W'(acc >> (n - 8)), USED_W'(8), 1'b0, 1'b0};
      cnt++;
      n -= 8;
    end
    acc = acc & ACC_W'((ACC_W'(1) << n) - 1);
    // flush on the chunk's last symbol
    if (w.final_symbol) begin
      if (n > 0) begin
        res[cnt] = {BYTE_W'(acc << (8 - n)), USED_W'(n), 1'b1, 1'b0};
        cnt++;
      end else if (cnt > 0) begin
        res[cnt-1].chunk_end = 1'b1;
      end
      acc = '0;
      n   = 0;
    end
    pend_bits = acc[PEND_W-1:0];
    pend_cnt  = PCNT_W'(n);
    if (cnt > 0) res[cnt-1].last = 1'b1;
  endfunction

  // offer one word after an idle gap, then queue its bytes once accepted
  task automatic send_word(input sym_word_t w, input int gap, input int n_typed,
                           input packed_byte_t t0, input packed_byte_t t1);
    packed_byte_t res [3];
    int           cnt;
    if (gap > 0) begin
      sym_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    sym_bus.valid        <= 1'b1;
    sym_bus.action       <= w.action;
    sym_bus.symbol       <= w.symbol;
    sym_bus.code_word    <= w.code_word;
    sym_bus.code_length  <= w.code_length;
    sym_bus.final_symbol <= w.final_symbol;
    @(posedge clk_i);
    while (!sym_bus.ready) @(posedge clk_i);
    n_words++;
    pack_symbol(w, res, cnt);
    if (n_typed == TYPED_NONE) begin
      for (int i = 0; i < cnt; i++) expected_bytes.push_back(res[i]);
    end else begin
      if (n_typed > 0) expected_bytes.push_back(t0);
      if (n_typed > 1) expected_bytes.push_back(t1);
    end
  endtask

  function automatic int sender_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic wait_drained();
    while (expected_bytes.size() != 0) @(posedge clk_i);
  endtask

  task automatic add_row(input logic act, input int sym, input int code, input int len,
                         input logic fin, input int n_typed, input packed_byte_t t0,
                         input packed_byte_t t1);
    dir_row_t r;
    r.w       = {act, SYMBOL_W'(sym), CODE_W'(code), LEN_W'(len), fin};
    r.n_typed = n_typed;
    r.t0      = t0;
    r.t1      = t1;
    dir_rows.push_back(r);
  endtask

  // compare one received byte word with the oldest expectation
  task automatic check_byte(input packed_byte_t got);
    packed_byte_t want;
    if (expected_bytes.size() == 0) begin
      $display("%0t: unexpected word, got %h/%0d/%b/%b", $time, got.data, got.used,
               got.chunk_end, got.last);
      errors++;
      return;
    end
    want = expected_bytes.pop_front();
    n_results++;
    if (got.chunk_end) n_chunks++;
    if (got.data !== want.data) begin
      $display("%0t: out_byte expected %h, actual %h", $time, want.data, got.data);
      errors++;
    end
    if (got.used !== want.used) begin
      $display("%0t: used_bits expected %0d, actual %0d", $time, want.used, got.used);
      errors++;
    end
    if (got.chunk_end !== want.chunk_end) begin
      $display("%0t: chunk_end expected %b, actual %b", $time, want.chunk_end,
               got.chunk_end);
      errors++;
    end
    if (got.last !== want.last) begin
      $display("%0t: last expected %b, actual %b", $time, want.last, got.last);
      errors++;
    end
  endtask

  // receiver: checks accepted words and paces ready
  initial begin : receiver
    int stall_left;
    int r;
    stall_left     = 0;
    byte_bus.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (byte_bus.valid && byte_bus.ready) begin
        check_byte({byte_bus.out_byte, byte_bus.used_bits, byte_bus.chunk_end,
                    byte_bus.last});
      end
      if (hold_req) begin
        hold_req       = 1'b0;
        stall_left     = HOLD_CYCLES;
        byte_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        byte_bus.ready <= 1'b0;
      end else if (steady) begin
        byte_bus.ready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          byte_bus.ready <= 1'b1;
        end else begin
          stall_left     = (r < 95) ? $urandom_range(0, 2) : $urandom_range(8, 25);
          byte_bus.ready <= 1'b0;
        end
      end
    end
  end

  // stimulus
  initial begin : stimulus
    sym_word_t w;
    int        r;
    int        loaded_syms [$];
    for (int i = 0; i < SYMBOL_COUNT_DEF; i++) begin
      code_tbl[i] = '0;
      len_tbl[i]  = '0;
    end
    pend_bits            = '0;
    pend_cnt             = '0;
    rst_ni               = 1'b0;
    sym_bus.valid        = 1'b0;
    sym_bus.action       = ACT_LOAD;
    sym_bus.symbol       = '0;
    sym_bus.code_word    = '0;
    sym_bus.code_length  = '0;
    sym_bus.final_symbol = 1'b0;

    // directed table: act, symbol, code, length, final, typed results
    add_row(ACT_ENCODE, 5, 0, 0, 1'b1, 0, NO_BYTE, NO_BYTE);        // nothing loaded yet
    add_row(ACT_LOAD, 127, 'h3FF, 10, 1'b1, 0, NO_BYTE, NO_BYTE);   // final ignored on load
    add_row(ACT_ENCODE, 127, 0, 0, 1'b1, 2, {8'hFF, 4'd8, 1'b0, 1'b0},
            {8'hC0, 4'd2, 1'b1, 1'b1});
    add_row(ACT_LOAD, 0, 'h3FF, 15, 1'b0, 0, NO_BYTE, NO_BYTE);     // length clamped
    add_row(ACT_ENCODE, 0, 0, 0, 1'b0, TYPED_NONE, NO_BYTE, NO_BYTE);
    add_row(ACT_ENCODE, 0, 0, 0, 1'b1, TYPED_NONE, NO_BYTE, NO_BYTE);
    add_row(ACT_LOAD, 1, 'h2AB, 8, 1'b0, 0, NO_BYTE, NO_BYTE);      // upper bits dropped
    add_row(ACT_ENCODE, 1, 0, 0, 1'b1, 1, {8'hAB, 4'd8, 1'b1, 1'b1}, NO_BYTE);
    add_row(ACT_LOAD, 2, 'h001, 1, 1'b0, 0, NO_BYTE, NO_BYTE);
    add_row(ACT_ENCODE, 2, 0, 0, 1'b0, 0, NO_BYTE, NO_BYTE);
    add_row(ACT_ENCODE, 2, 0, 0, 1'b1, 1, {8'hC0, 4'd2, 1'b1, 1'b1}, NO_BYTE);
    // closing byte came earlier, final emits nothing
    add_row(ACT_ENCODE, 1, 0, 0, 1'b0, 1, {8'hAB, 4'd8, 1'b0, 1'b1}, NO_BYTE);
    add_row(ACT_ENCODE, 5, 0, 0, 1'b1, 0, NO_BYTE, NO_BYTE);
    // earlier pending bit flushed by a zero-length final
    add_row(ACT_ENCODE, 2, 0, 0, 1'b0, 0, NO_BYTE, NO_BYTE);
    add_row(ACT_ENCODE, 5, 0, 0, 1'b1, 1, {8'h80, 4'd1, 1'b1, 1'b1}, NO_BYTE);
    add_row(ACT_LOAD, 3, 'h3FF, 0, 1'b0, 0, NO_BYTE, NO_BYTE);      // zero length
    add_row(ACT_ENCODE, 3, 0, 0, 1'b1, 0, NO_BYTE, NO_BYTE);
    // seven pending plus ten bits: three bytes from one word
    add_row(ACT_LOAD, 6, 'h07F, 7, 1'b0, 0, NO_BYTE, NO_BYTE);
    add_row(ACT_ENCODE, 6, 0, 0, 1'b0, 0, NO_BYTE, NO_BYTE);
    add_row(ACT_ENCODE, 127, 0, 0, 1'b1, TYPED_NONE, NO_BYTE, NO_BYTE);
    add_row(ACT_LOAD, 0, 'h155, 10, 1'b0, TYPED_NONE, NO_BYTE, NO_BYTE);
    add_row(ACT_LOAD, 127, 'h000, 10, 1'b0, TYPED_NONE, NO_BYTE, NO_BYTE);
    add_row(ACT_ENCODE, 0, 0, 0, 1'b0, TYPED_NONE, NO_BYTE, NO_BYTE);
    add_row(ACT_ENCODE, 127, 0, 0, 1'b0, TYPED_NONE, NO_BYTE, NO_BYTE);
    add_row(ACT_ENCODE, 6, 0, 0, 1'b1, TYPED_NONE, NO_BYTE, NO_BYTE);

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      send_word(dir_rows[i].w, sender_gap(), dir_rows[i].n_typed, dir_rows[i].t0,
                dir_rows[i].t1);
    end
    sym_bus.valid <= 1'b0;
    wait_drained();
    @(posedge clk_i);

    // random part: fill part of the table, then chunks mostly of loaded symbols
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i == 150) hold_req = 1'b1;
      steady = (i >= 150 && i < 200) || (i >= 260 && i < 300);
      if (i == 320) begin
        sym_bus.valid <= 1'b0;
        wait_drained();
        @(posedge clk_i);
      end
      r = $urandom_range(0, 99);
      if (i < PRELOAD_WORDS || r < 12) begin
        w.action      = ACT_LOAD;
        w.symbol      = SYMBOL_W'($urandom_range(0, SYMBOL_COUNT_DEF - 1));
        w.code_word   = CODE_W'($urandom_range(0, 1023));
        w.code_length = ($urandom_range(0, 9) == 0) ? LEN_W'($urandom_range(0, 15))
                                                    : LEN_W'($urandom_range(1, 10));
        loaded_syms.push_back(int'(w.symbol));
      end else begin
        w.action = ACT_ENCODE;
        if ($urandom_range(0, 9) == 0) begin
          w.symbol = SYMBOL_W'($urandom_range(0, SYMBOL_COUNT_DEF - 1));
        end else begin
          w.symbol = SYMBOL_W'(loaded_syms[$urandom_range(0, loaded_syms.size() - 1)]);
        end
        w.code_word   = CODE_W'($urandom_range(0, 1023));
        w.code_length = LEN_W'($urandom_range(0, 15));
      end
      w.final_symbol = ($urandom_range(0, 5) == 0);
      send_word(w, sender_gap(), TYPED_NONE, NO_BYTE, NO_BYTE);
    end
    steady        = 1'b0;
    sym_bus.valid <= 1'b0;

    // drain, then a quiet tail to catch stray words
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d symbol words (loads and encodes), received %0d byte words,",
             n_words, n_results);
    $display("%0d of them closing a chunk; %0d mismatches.", n_chunks, errors);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/hcbp_pkg.sv
src/hcbp_if.sv
src/hcbp_ram.sv
src/hcbp_code_table.sv
src/hcbp_packer.sv
src/huffman_code_bit_packer_top.sv
test/testbench.sv
